// ----- hdl/pspb_pkg.sv -----
// ----------------------------------------------------------------------------
// pspb_pkg
// Shared types and constants of the palette sprite blitter: register codes,
// queue item layout, config bundle and the links between front, back and
// pixel stage.
// ----------------------------------------------------------------------------
package pspb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 384;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int OFFSET_W    = 18;
  localparam int COLOR_W     = 16;
  localparam int INDEX_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int COLUMN_W    = 9;
  localparam int ROW_W       = 8;
  localparam int COL_SUM_W   = COLUMN_W + 1;
  localparam int ROW_SUM_W   = ROW_W + 1;
  localparam int PIXEL_CNT_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_COLUMN  = 3'd0,
    REG_ORIGIN_ROW     = 3'd1,
    REG_SPRITE_COLUMNS = 3'd2,
    REG_SPRITE_ROWS    = 3'd3,
    REG_BITS_CODE      = 3'd4,
    REG_KEY_COLOR      = 3'd5
  } reg_index_t;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXELS  = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BITS_1 = 2'd0,
    BITS_2 = 2'd1,
    BITS_4 = 2'd2,
    BITS_8 = 2'd3
  } bits_code_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [COLOR_W-1:0]  entry_color;
    logic [BYTE_W-1:0]   packed_byte;
  } queue_item_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] origin_column;
    logic [ROW_W-1:0]    origin_row;
    logic [COLUMN_W-1:0] sprite_columns;
    logic [ROW_W-1:0]    sprite_rows;
    logic [1:0]          bits_code;
  } blit_cfg_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [COLOR_W-1:0] color;
  } pal_write_t;

  typedef struct packed {
    logic                 valid;
    logic [INDEX_W-1:0]   index;
    logic [OFFSET_W-1:0]  row_base;
    logic [COL_SUM_W-1:0] col_sum;
    logic                 byte_last;
    logic                 sprite_last;
  } pix_cmd_t;

endpackage

// ----- hdl/packed_palette_sprite_blitter_top.sv -----
// ----------------------------------------------------------------------------
// packed_palette_sprite_blitter_top
// Color keyed palette sprite blitter: palette writes and packed sprite bytes
// in, one keyed pixel write per output beat.
// ----------------------------------------------------------------------------
// path: a pixel byte goes through queue, palette read and output registers
// throughput: one pixel per cycle from the back end sequencer while the pixel
//   stage takes it; a byte gives 1 to 8 pixels (by bit width, cut at a row end)
// reset: counters and queue clear, config registers take defaults; palette
//   memory is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
module packed_palette_sprite_blitter_top import pspb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [INDEX_W-1:0]     entry_index,
  input  logic [COLOR_W-1:0]     entry_color,
  input  logic [BYTE_W-1:0]      packed_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_W-1:0]    pixel_offset,
  output logic [COLOR_W-1:0]     pixel_color,
  output logic                   write_enable,
  output logic                   byte_last,
  output logic                   sprite_last
);

  blit_cfg_t          cfg;
  logic [COLOR_W-1:0] key_color;

  logic               q_valid;
  queue_item_t        q_head;
  logic               q_pop;
  pal_write_t         pal_wr;
  pix_cmd_t           pix_cmd;
  logic               pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_column  <= '0;
      cfg.origin_row     <= '0;
      cfg.sprite_columns <= COLUMN_W'(1);
      cfg.sprite_rows    <= ROW_W'(1);
      cfg.bits_code      <= BITS_8;
      key_color          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_COLUMN:  cfg.origin_column  <= cfg_data[COLUMN_W-1:0];
        REG_ORIGIN_ROW:     cfg.origin_row     <= cfg_data[ROW_W-1:0];
        REG_SPRITE_COLUMNS: cfg.sprite_columns <= cfg_data[COLUMN_W-1:0];
        REG_SPRITE_ROWS:    cfg.sprite_rows    <= cfg_data[ROW_W-1:0];
        REG_BITS_CODE:      cfg.bits_code      <= cfg_data[1:0];
        REG_KEY_COLOR:      key_color          <= cfg_data;
        default: ;
      endcase
    end
  end

  pspb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .packed_byte (packed_byte),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  pspb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pal_wr    (pal_wr),
    .pix_cmd   (pix_cmd),
    .pix_ready (pix_ready)
  );

  pspb_pixel #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_pixel (
    .clk          (clk),
    .rst          (rst),
    .key_color    (key_color),
    .pal_wr       (pal_wr),
    .pix_cmd      (pix_cmd),
    .pix_ready    (pix_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_offset (pixel_offset),
    .pixel_color  (pixel_color),
    .write_enable (write_enable),
    .byte_last    (byte_last),
    .sprite_last  (sprite_last)
  );

  // the back end never writes the palette and issues a pixel in the same cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    pal_wr.en |-> !pix_cmd.valid)
    else $error("palette write and pixel issue in the same cycle");

  // the last pixel of a sprite always closes its byte
  a_sprite_closes_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!sprite_last || byte_last))
    else $error("sprite_last without byte_last");

  // a popped beat must exist in the queue
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // reset leaves no beat on the output and the queue open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output or queue not clean after reset");

endmodule

// ----- hdl/pspb_front.sv -----
// ----------------------------------------------------------------------------
// pspb_front
// Input side: takes beats, sorts them into palette writes and pixel bytes and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pspb_front import pspb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [COLOR_W-1:0]  entry_color,
  input  logic [BYTE_W-1:0]   packed_byte,
  output logic                q_valid,
  output queue_item_t         q_head,
  input  logic                q_pop
);

  queue_item_t         slots [QUEUE_DEPTH];
  queue_item_t         item;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic [QPTR_W:0]     count_next;
  logic                push;

  assign in_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = slots[rd_ptr];

  // classify
  always_comb begin
    item.kind = cmd_kind_t'(mode);
    if (item.kind == CMD_PIXELS) begin
      item.entry_index = '0;
      item.entry_color = '0;
      item.packed_byte = packed_byte;
    end else begin
      item.entry_index = entry_index;
      item.entry_color = entry_color;
      item.packed_byte = '0;
    end
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + (QPTR_W+1)'(1);
      2'b01:   count_next = count - (QPTR_W+1)'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

endmodule

// ----- hdl/pspb_back.sv -----
// ----------------------------------------------------------------------------
// pspb_back
// Back end sequencer: applies palette writes in order, unpacks pixel bytes one
// pixel per cycle while pix_ready, stepping sprite column and row counters.
// ----------------------------------------------------------------------------
module pspb_back import pspb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  blit_cfg_t   cfg,
  input  logic        q_valid,
  input  queue_item_t q_head,
  output logic        q_pop,
  output pal_write_t  pal_wr,
  output pix_cmd_t    pix_cmd,
  input  logic        pix_ready
);

  logic                   busy;
  logic [BYTE_W-1:0]      shreg;
  logic [PIXEL_CNT_W-1:0] k;
  logic [COLUMN_W-1:0]    column;
  logic [ROW_W-1:0]       row;

  logic [BYTE_W-1:0]      cur_byte;
  logic [PIXEL_CNT_W-1:0] cur_k;
  logic [PIXEL_CNT_W-1:0] last_k;
  logic [BYTE_W-1:0]      shifted;
  logic [INDEX_W-1:0]     index;
  logic                   head_pixels;
  logic                   head_palette;
  logic                   issue;
  logic [COLUMN_W-1:0]    cols;
  logic [ROW_W-1:0]       rows;
  logic [COLUMN_W-1:0]    column_inc;
  logic [ROW_W-1:0]       row_inc;
  logic                   row_end;
  logic                   spr_end;
  logic                   byte_done;
  logic [ROW_SUM_W-1:0]   row_sum;
  logic [OFFSET_W-1:0]    row_base;
  logic [COL_SUM_W-1:0]   col_sum;

  assign cur_byte     = busy ? shreg : q_head.packed_byte;
  assign cur_k        = busy ? k : '0;
  assign head_pixels  = q_valid && (q_head.kind == CMD_PIXELS);
  assign head_palette = q_valid && (q_head.kind == CMD_PALETTE);
  assign issue        = pix_ready && (busy || head_pixels);

  assign pal_wr.en    = !busy && head_palette;
  assign pal_wr.addr  = q_head.entry_index;
  assign pal_wr.color = q_head.entry_color;
  assign q_pop        = pal_wr.en || (issue && !busy);

  // msb-first unpack
  always_comb begin
    unique case (bits_code_t'(cfg.bits_code))
      BITS_1: begin
        index   = {7'b0, cur_byte[7]};
        shifted = {cur_byte[6:0], 1'b0};
        last_k  = PIXEL_CNT_W'(7);
      end
      BITS_2: begin
        index   = {6'b0, cur_byte[7:6]};
        shifted = {cur_byte[5:0], 2'b0};
        last_k  = PIXEL_CNT_W'(3);
      end
      BITS_4: begin
        index   = {4'b0, cur_byte[7:4]};
        shifted = {cur_byte[3:0], 4'b0};
        last_k  = PIXEL_CNT_W'(1);
      end
      BITS_8: begin
        index   = cur_byte;
        shifted = '0;
        last_k  = '0;
      end
    endcase
  end

  assign cols       = (cfg.sprite_columns == '0) ? COLUMN_W'(1) : cfg.sprite_columns;
  assign rows       = (cfg.sprite_rows == '0) ? ROW_W'(1) : cfg.sprite_rows;
  assign column_inc = column + COLUMN_W'(1);
  assign row_inc    = row + ROW_W'(1);
  assign row_end    = (column_inc >= cols) || (column_inc == '0);
  assign spr_end    = row_end && ((row_inc >= rows) || (row_inc == '0));
  assign byte_done  = row_end || (cur_k == last_k);

  assign row_sum  = {1'b0, cfg.origin_row} + {1'b0, row};
  assign row_base = OFFSET_W'(row_sum) * OFFSET_W'(SCREEN_WIDTH);
  assign col_sum  = {1'b0, cfg.origin_column} + {1'b0, column};

  assign pix_cmd.valid       = issue;
  assign pix_cmd.index       = index;
  assign pix_cmd.row_base    = row_base;
  assign pix_cmd.col_sum     = col_sum;
  assign pix_cmd.byte_last   = byte_done;
  assign pix_cmd.sprite_last = spr_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      k      <= '0;
      column <= '0;
      row    <= '0;
    end else if (issue) begin
      column <= row_end ? '0 : column_inc;
      if (row_end) begin
        row <= spr_end ? '0 : row_inc;
      end
      if (byte_done) begin
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
        k    <= cur_k + PIXEL_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      shreg <= shifted;
    end
  end

endmodule

// ----- hdl/pspb_pixel.sv -----
// ----------------------------------------------------------------------------
// pspb_pixel
// Pixel stage: palette memory with registered read, offset add, color key
// compare and the output register toward the frame buffer side.
// ----------------------------------------------------------------------------
module pspb_pixel import pspb_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [COLOR_W-1:0]  key_color,
  input  pal_write_t          pal_wr,
  input  pix_cmd_t            pix_cmd,
  output logic                pix_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OFFSET_W-1:0] pixel_offset,
  output logic [COLOR_W-1:0]  pixel_color,
  output logic                write_enable,
  output logic                byte_last,
  output logic                sprite_last
);

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);

  logic [COLOR_W-1:0]   palette [PALETTE_DEPTH];
  logic [COLOR_W-1:0]   rd_data;
  logic                 wr_in_range;
  logic                 rd_in_range;

  logic                 b_valid;
  logic [OFFSET_W-1:0]  b_row_base;
  logic [COL_SUM_W-1:0] b_col_sum;
  logic                 b_oor;
  logic                 b_byte_last;
  logic                 b_sprite_last;

  logic                 advance;
  logic [COLOR_W-1:0]   color;

  assign wr_in_range = ({1'b0, pal_wr.addr} < (INDEX_W+1)'(PALETTE_DEPTH));
  assign rd_in_range = ({1'b0, pix_cmd.index} < (INDEX_W+1)'(PALETTE_DEPTH));
  assign advance     = !out_valid || out_ready;
  assign pix_ready   = !b_valid || advance;
  assign color       = b_oor ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (pal_wr.en && wr_in_range) begin
      palette[pal_wr.addr[ADDR_W-1:0]] <= pal_wr.color;
    end
    if (pix_cmd.valid) begin
      rd_data <= palette[pix_cmd.index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_cmd.valid) begin
        b_valid <= 1'b1;
      end else if (advance) begin
        b_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_cmd.valid) begin
      b_row_base    <= pix_cmd.row_base;
      b_col_sum     <= pix_cmd.col_sum;
      b_oor         <= !rd_in_range;
      b_byte_last   <= pix_cmd.byte_last;
      b_sprite_last <= pix_cmd.sprite_last;
    end
    if (advance && b_valid) begin
      pixel_offset <= b_row_base + OFFSET_W'(b_col_sum);
      pixel_color  <= color;
      write_enable <= (color != key_color);
      byte_last    <= b_byte_last;
      sprite_last  <= b_sprite_last;
    end
  end

endmodule
